### design/mac_learning_forwarder_macros.svh
// Assertion macros shared by the MAC learning forwarder RTL.
`ifndef MAC_LEARNING_FORWARDER_MACROS_SVH
`define MAC_LEARNING_FORWARDER_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge of clk_i, quiet while rst_ni is low.
`define MLF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Same-cycle implication.
`define MLF_ASSERT_IMPL(name, ante, cons, msg) \
  `MLF_ASSERT(name, (ante) |-> (cons), msg)
// Next-cycle implication.
`define MLF_ASSERT_NEXT(name, ante, cons, msg) \
  `MLF_ASSERT(name, (ante) |=> (cons), msg)
`else
`define MLF_ASSERT(name, prop, msg)
`define MLF_ASSERT_IMPL(name, ante, cons, msg)
`define MLF_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

### design/mlf_pkg.sv
// Types and constants of the MAC learning forwarder.
package mlf_pkg;

  localparam int unsigned TableDepth  = 64;
  localparam int unsigned MaxPorts    = 4;
  localparam int unsigned NumPortRegs = 4;
  localparam int unsigned ActivePortLimit = (MaxPorts < NumPortRegs) ? MaxPorts : NumPortRegs;

  localparam int unsigned MacW      = 48;
  localparam int unsigned PortW     = 2;
  localparam int unsigned MaskW     = NumPortRegs;
  localparam int unsigned NumPortsW = 3;
  localparam int unsigned IdxW      = $clog2(TableDepth);
  localparam int unsigned CntW      = $clog2(TableDepth + 1);
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 48;

  localparam logic [MacW-1:0] BroadcastMac = '1;
  localparam logic [NumPortsW-1:0] NumPortsReset = NumPortsW'(2);

  typedef logic [MacW-1:0]  mac_t;
  typedef logic [PortW-1:0] port_t;

  typedef enum logic [1:0] {
    ACT_FORWARD = 2'd0,
    ACT_FLOOD   = 2'd1,
    ACT_LOCAL   = 2'd2
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NUM_PORTS  = 3'd0,
    CFG_PORT_MAC_0 = 3'd1,
    CFG_PORT_MAC_1 = 3'd2,
    CFG_PORT_MAC_2 = 3'd3,
    CFG_PORT_MAC_3 = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    mac_t  mac;
    port_t port;
  } entry_t;

endpackage

### design/mlf_if.sv
// Request and response channel interfaces of the MAC learning forwarder.
interface mlf_req_if import mlf_pkg::*; ();
  logic  valid;
  logic  ready;
  mac_t  src_mac;
  mac_t  dst_mac;
  port_t ingress_port;

  modport source (output valid, output src_mac, output dst_mac, output ingress_port,
                  input ready);
  modport sink   (input valid, input src_mac, input dst_mac, input ingress_port,
                  output ready);
endinterface

interface mlf_rsp_if import mlf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       action;
  port_t            egress_port;
  logic [MaskW-1:0] flood_mask;
  logic             learned_new;
  logic             table_wrapped;

  modport source (output valid, output action, output egress_port, output flood_mask,
                  output learned_new, output table_wrapped, input ready);
  modport sink   (input valid, input action, input egress_port, input flood_mask,
                  input learned_new, input table_wrapped, output ready);
endinterface

### design/mac_learning_forwarder.sv
// Top level of the MAC learning forwarder: table walk, learning and forwarding decision.
//
// Each request carries one frame's source MAC, destination MAC and ingress port and yields
// exactly one response. The block walks the learned entries in the table memory, one entry
// per cycle through its single read port, matching source and destination in the same
// pass; it then writes the source entry back (port update on a hit, append on a miss, with
// restart at index 0 when the table is full) and decides: local delivery for broadcast or
// a switch port MAC, forward on a destination hit, otherwise flood to the active ports
// except ingress. With an empty table the walk is skipped; a new request is taken while the
// previous response still waits in the output register. The table needs no clearing after
// reset: only entries below the count are read.
`include "mac_learning_forwarder_macros.svh"

module mac_learning_forwarder import mlf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  mlf_req_if.sink             req_i,
  mlf_rsp_if.source           rsp_o
);

  // configuration
  logic [NumPortsW-1:0] num_ports_q;
  mac_t                 port_mac_q [NumPortRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ports_q <= NumPortsReset;
      for (int i = 0; i < NumPortRegs; i++) begin
        port_mac_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NUM_PORTS:  num_ports_q   <= cfg_wdata_i[NumPortsW-1:0];
        CFG_PORT_MAC_0: port_mac_q[0] <= cfg_wdata_i[MacW-1:0];
        CFG_PORT_MAC_1: port_mac_q[1] <= cfg_wdata_i[MacW-1:0];
        CFG_PORT_MAC_2: port_mac_q[2] <= cfg_wdata_i[MacW-1:0];
        CFG_PORT_MAC_3: port_mac_q[3] <= cfg_wdata_i[MacW-1:0];
        default: ;
      endcase
    end
  end

  // control and datapath state
  state_e          state_q, state_d;
  mac_t            src_q, dst_q;
  port_t           ing_q;
  logic [IdxW-1:0] idx_q, cmp_idx_q, src_idx_q;
  logic            rvalid_q;
  logic            src_hit_q, dst_hit_q;
  port_t           dst_port_q;
  logic [CntW-1:0] count_q;

  logic             rsp_valid_q;
  action_e          rsp_action_q;
  port_t            rsp_egress_q;
  logic [MaskW-1:0] rsp_mask_q;
  logic             rsp_learned_q, rsp_wrapped_q;

  logic            accept;
  logic            walk_last;
  logic            ram_we;
  logic            finish_go;
  entry_t          rdata;
  logic [IdxW-1:0] waddr;
  entry_t          wdata;

  assign accept    = req_i.valid && req_i.ready;
  assign walk_last = (CntW'(idx_q) + CntW'(1)) == count_q;

  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    ram_we      = 1'b0;
    finish_go   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          state_d = (count_q == '0) ? ST_FINISH : ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        // rewriting the same entry while the response slot is busy is harmless
        ram_we = 1'b1;
        if (!rsp_valid_q || rsp_o.ready) begin
          finish_go = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  mlf_ram #(
    .Width ($bits(entry_t)),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  // decision, evaluated from registered walk results while finishing
  logic [NumPortsW-1:0]   nports;
  logic [NumPortRegs-1:0] port_active;
  logic [MaskW-1:0]       flood_mask;
  logic                   is_local;
  logic                   wrap;
  action_e                action;
  port_t                  egress;
  logic [MaskW-1:0]       mask;
  logic [CntW-1:0]        count_next;

  always_comb begin
    nports = (num_ports_q > NumPortsW'(ActivePortLimit)) ?
             NumPortsW'(ActivePortLimit) : num_ports_q;
    is_local = (dst_q == BroadcastMac);
    for (int i = 0; i < NumPortRegs; i++) begin
      port_active[i] = NumPortsW'(i) < nports;
      flood_mask[i]  = port_active[i] && (PortW'(i) != ing_q);
      if (port_active[i] && (port_mac_q[i] == dst_q)) begin
        is_local = 1'b1;
      end
    end

    wrap  = !src_hit_q && (count_q == CntW'(TableDepth));
    waddr = src_hit_q ? src_idx_q : (wrap ? '0 : count_q[IdxW-1:0]);
    wdata = '{mac: src_q, port: ing_q};

    action = ACT_FLOOD;
    egress = '0;
    mask   = '0;
    if (is_local) begin
      action = ACT_LOCAL;
    end else if (dst_q == src_q) begin
      // the source entry just learned is the first match
      action = ACT_FORWARD;
      egress = ing_q;
    end else if (!wrap && dst_hit_q) begin
      // after a restart only the new entry lies below the count
      action = ACT_FORWARD;
      egress = dst_port_q;
    end else begin
      mask = flood_mask;
    end

    if (src_hit_q) begin
      count_next = count_q;
    end else if (wrap) begin
      count_next = CntW'(1);
    end else begin
      count_next = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      rvalid_q    <= 1'b0;
      src_hit_q   <= 1'b0;
      dst_hit_q   <= 1'b0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      rvalid_q <= (state_q == ST_WALK);
      if (accept) begin
        idx_q     <= '0;
        src_hit_q <= 1'b0;
        dst_hit_q <= 1'b0;
      end else if (state_q == ST_WALK) begin
        idx_q <= idx_q + IdxW'(1);
      end
      // keep the first match of each address
      if (rvalid_q) begin
        if (!src_hit_q && (rdata.mac == src_q)) begin
          src_hit_q <= 1'b1;
        end
        if (!dst_hit_q && (rdata.mac == dst_q)) begin
          dst_hit_q <= 1'b1;
        end
      end
      if (finish_go) begin
        count_q     <= count_next;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_q <= req_i.src_mac;
      dst_q <= req_i.dst_mac;
      ing_q <= req_i.ingress_port;
    end
    if (state_q == ST_WALK) begin
      cmp_idx_q <= idx_q;
    end
    if (rvalid_q) begin
      if (!src_hit_q && (rdata.mac == src_q)) begin
        src_idx_q <= cmp_idx_q;
      end
      if (!dst_hit_q && (rdata.mac == dst_q)) begin
        dst_port_q <= rdata.port;
      end
    end
    if (finish_go) begin
      rsp_action_q  <= action;
      rsp_egress_q  <= egress;
      rsp_mask_q    <= mask;
      rsp_learned_q <= !src_hit_q;
      rsp_wrapped_q <= wrap;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.action        = rsp_action_q;
  assign rsp_o.egress_port   = rsp_egress_q;
  assign rsp_o.flood_mask    = rsp_mask_q;
  assign rsp_o.learned_new   = rsp_learned_q;
  assign rsp_o.table_wrapped = rsp_wrapped_q;

  `MLF_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != ST_IDLE, "request did not start a lookup")
  `MLF_ASSERT_IMPL(a_walk_nonempty, state_q == ST_WALK, count_q != '0, "walk over an empty table")
  `MLF_ASSERT(a_count_bound, count_q <= CntW'(TableDepth), "entry count beyond table depth")
  `MLF_ASSERT_NEXT(a_finish_result, finish_go, rsp_valid_q, "finished lookup left no response")

endmodule

### design/mlf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mlf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### verif/mac_learning_forwarder_tb.sv
// Self-checking testbench: MAC learning forwarder with in-bench table model and ready/valid idling.
module mac_learning_forwarder_tb;
  import mlf_pkg::*;

  localparam int unsigned MacPoolSize = 96;
  localparam int unsigned RandPerPhase = 475;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned TimeoutNs = 8_000_000;

  localparam mac_t MacA = 48'h0010_2030_4050;
  localparam mac_t MacB = 48'h0010_2030_4051;
  localparam mac_t MacC = 48'h0010_2030_4052;
  localparam mac_t MacD = 48'h0010_2030_4053;
  localparam mac_t MacE = 48'h0010_2030_4054;
  localparam mac_t MacF = 48'h0010_2030_4055;
  localparam mac_t MacStripeHi = 48'hAAAA_AAAA_AAAA;
  localparam mac_t MacStripeLo = 48'h5555_5555_5555;

  typedef struct packed {
    mac_t  src;
    mac_t  dst;
    port_t ingress;
  } frame_t;

  typedef struct packed {
    action_e          action;
    port_t            egress;
    logic [MaskW-1:0] flood_mask;
    logic             learned_new;
    logic             table_wrapped;
  } decision_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  mlf_req_if frame_req ();
  mlf_rsp_if decision_rsp ();

  mac_learning_forwarder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (frame_req),
    .rsp_o      (decision_rsp)
  );

  // Forwarding table and register copies
  mac_t                 fdb_mac [TableDepth];
  port_t                fdb_port [TableDepth];
  int unsigned          fdb_count;
  logic [NumPortsW-1:0] cfg_num_ports;
  mac_t                 cfg_port_mac [NumPortRegs];

  frame_t      frame_q[$];
  decision_t   decision_q[$];
  mac_t        mac_pool [MacPoolSize];
  int unsigned frames_queued;
  int unsigned frames_taken;
  int unsigned decisions_checked;
  int unsigned errors;
  int unsigned n_forward, n_flood, n_local, n_learned, n_wrapped;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          req_taken;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #(TimeoutNs);
    $display("timeout: %0d of %0d requests taken, %0d decisions outstanding",
             frames_taken, frames_queued, decision_q.size());
    $display("FAIL");
    $finish;
  end

  function automatic mac_t random_mac();
    return mac_t'({$urandom(), $urandom()});
  endfunction

  function automatic bit fdb_lookup(mac_t mac, output int unsigned idx);
    int unsigned i;
    idx = 0;
    for (i = 0; i < fdb_count && i < TableDepth; i++) begin
      if (fdb_mac[i] == mac) begin
        idx = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Learn the source first, then decide on the destination
  function automatic decision_t forward_decision(frame_t f);
    decision_t   d;
    int unsigned idx;
    int unsigned nports;
    int unsigned i;
    bit          to_cpu;
    d = '0;
    d.action = ACT_FORWARD;
    nports = (cfg_num_ports > ActivePortLimit) ? ActivePortLimit : cfg_num_ports;
    if (fdb_lookup(f.src, idx)) begin
      fdb_port[idx] = f.ingress;
    end else begin
      if (fdb_count >= TableDepth) begin
        fdb_count = 0;
        d.table_wrapped = 1'b1;
      end
      fdb_mac[fdb_count] = f.src;
      fdb_port[fdb_count] = f.ingress;
      fdb_count++;
      d.learned_new = 1'b1;
    end
    to_cpu = (f.dst == BroadcastMac);
    for (i = 0; i < nports; i++) begin
      if (cfg_port_mac[i] == f.dst) to_cpu = 1'b1;
    end
    if (to_cpu) begin
      d.action = ACT_LOCAL;
    end else if (fdb_lookup(f.dst, idx)) begin
      d.action = ACT_FORWARD;
      d.egress = fdb_port[idx];
    end else begin
      d.action = ACT_FLOOD;
      for (i = 0; i < nports; i++) begin
        if (i != f.ingress) d.flood_mask[i] = 1'b1;
      end
    end
    return d;
  endfunction

  function automatic frame_t random_frame();
    frame_t      f;
    int unsigned pick;
    pick = $urandom_range(99);
    f.src = (pick < 70) ? mac_pool[$urandom_range(MacPoolSize - 1)] : random_mac();
    pick = $urandom_range(99);
    if (pick < 15) f.dst = BroadcastMac;
    else if (pick < 25) f.dst = cfg_port_mac[$urandom_range(NumPortRegs - 1)];
    else if (pick < 30) f.dst = f.src;
    else if (pick < 85) f.dst = mac_pool[$urandom_range(MacPoolSize - 1)];
    else f.dst = random_mac();
    f.ingress = port_t'($urandom());
    return f;
  endfunction

  task automatic send_frame(mac_t src, mac_t dst, port_t ingress);
    frame_q.push_back('{src: src, dst: dst, ingress: ingress});
    frames_queued++;
  endtask

  // Hold until every request is taken and every decision checked
  task automatic drain();
    while (frames_taken != frames_queued || decision_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_NUM_PORTS: cfg_num_ports = data[NumPortsW-1:0];
      CFG_PORT_MAC_0, CFG_PORT_MAC_1, CFG_PORT_MAC_2, CFG_PORT_MAC_3: begin
        cfg_port_mac[idx - CFG_PORT_MAC_0] = data[MacW-1:0];
      end
      default: ;
    endcase
  endtask

  // Upper bits of the port-count write are don't-care
  task automatic set_ports(logic [NumPortsW-1:0] n, mac_t m0, mac_t m1, mac_t m2, mac_t m3);
    write_reg(CFG_NUM_PORTS, {random_mac()} << NumPortsW | CfgDataW'(n));
    write_reg(CFG_PORT_MAC_0, m0);
    write_reg(CFG_PORT_MAC_1, m1);
    write_reg(CFG_PORT_MAC_2, m2);
    write_reg(CFG_PORT_MAC_3, m3);
  endtask

  // Driver: present requests at the falling edge, hold until taken
  always @(negedge clk_i) begin
    frame_t next_frame;
    if (!rst_ni) begin
      frame_req.valid <= 1'b0;
    end else if (!frame_req.valid || req_taken) begin
      if (frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_frame = frame_q.pop_front();
        frame_req.valid <= 1'b1;
        frame_req.src_mac <= next_frame.src;
        frame_req.dst_mac <= next_frame.dst;
        frame_req.ingress_port <= next_frame.ingress;
      end else begin
        frame_req.valid <= 1'b0;
      end
    end
    decision_rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: predict on request, check on response
  always @(posedge clk_i) begin
    decision_t want;
    decision_t got;
    req_taken = rst_ni && frame_req.valid && frame_req.ready;
    if (req_taken) begin
      want = forward_decision('{src: frame_req.src_mac, dst: frame_req.dst_mac,
                                ingress: frame_req.ingress_port});
      decision_q.push_back(want);
      frames_taken++;
      case (want.action)
        ACT_FORWARD: n_forward++;
        ACT_FLOOD:   n_flood++;
        default:     n_local++;
      endcase
      n_learned += want.learned_new;
      n_wrapped += want.table_wrapped;
    end
    if (rst_ni && decision_rsp.valid && decision_rsp.ready) begin
      got.action = action_e'(decision_rsp.action);
      got.egress = decision_rsp.egress_port;
      got.flood_mask = decision_rsp.flood_mask;
      got.learned_new = decision_rsp.learned_new;
      got.table_wrapped = decision_rsp.table_wrapped;
      if (decision_q.size() == 0) begin
        errors++;
        if (errors <= ReportLimit) $display("%0t: response with no request outstanding", $realtime);
      end else begin
        want = decision_q.pop_front();
        decisions_checked++;
        if (got !== want) begin
          errors++;
          if (errors <= ReportLimit) begin
            $display("%0t: decision %0d mismatch: exp act %0d egr %0d mask %b new %b wrap %b",
                     $realtime, decisions_checked, want.action, want.egress, want.flood_mask,
                     want.learned_new, want.table_wrapped);
            $display("%0t:                       got act %0d egr %0d mask %b new %b wrap %b",
                     $realtime, got.action, got.egress, got.flood_mask, got.learned_new,
                     got.table_wrapped);
          end
        end
      end
    end
  end

  initial begin
    int unsigned i;
    int unsigned k;
    int unsigned phase;
    logic [NumPortsW-1:0] phase_ports;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    frame_req.valid = 1'b0;
    frame_req.src_mac = '0;
    frame_req.dst_mac = '0;
    frame_req.ingress_port = '0;
    decision_rsp.ready = 1'b0;
    req_taken = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fdb_count = 0;
    cfg_num_ports = NumPortsReset;
    for (i = 0; i < NumPortRegs; i++) cfg_port_mac[i] = '0;
    for (i = 0; i < MacPoolSize; i++) mac_pool[i] = random_mac();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values: two ports, all port MACs zero
    send_frame(MacA, '0, 2);
    drain();

    // Four ports: learning, hits, forward back to ingress, flooding
    set_ports(4, 48'h0200_0000_0A00, 48'h0200_0000_0A01, 48'h0200_0000_0A02,
              48'h0200_0000_0A03);
    send_frame(MacA, BroadcastMac, 0);
    send_frame(MacB, MacA, 1);
    send_frame(MacA, MacA, 2);
    send_frame(MacC, MacD, 3);
    send_frame(MacD, MacB, 0);
    send_frame('0, 48'h0200_0000_0A03, 1);
    send_frame('1, 48'h0200_0000_0A00, 2);
    send_frame(MacB, '0, 3);
    send_frame(MacC, MacStripeLo, 0);
    send_frame(MacStripeHi, MacStripeLo, 1);
    drain();

    // No active ports: port MACs never match, flood mask empty
    write_reg(CFG_NUM_PORTS, 0);
    send_frame(MacE, 48'h0200_0000_0A00, 2);
    send_frame(MacE, MacE, 1);
    drain();

    // One port, ingress outside the active set
    set_ports(1, '1, 48'h0200_0000_0B01, '0, 48'h0200_0000_0B03);
    send_frame(MacF, 48'h1234_5678_9ABC, 3);
    send_frame(MacF, 48'h1234_5678_9ABD, 0);
    send_frame(MacA, 48'h0200_0000_0B01, 1);
    drain();

    // Port count above the limit saturates
    write_reg(CFG_NUM_PORTS, '1);
    send_frame(MacA, '0, 1);
    send_frame(MacB, 48'h0200_0000_0B03, 2);
    send_frame(MacC, 48'h0200_0000_0C00, 2);
    drain();

    // Writes to unmapped indexes must be dropped
    for (k = NumPortRegs + 1; k < (1 << CfgIdxW); k++) write_reg(CfgIdxW'(k), random_mac());
    send_frame(MacD, 48'h0200_0000_0B01, 0);
    send_frame(MacE, MacStripeHi, 3);
    drain();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  phase_ports = 4; end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  phase_ports = 3; end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; phase_ports = 2; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; phase_ports = 5; end
      endcase
      set_ports(phase_ports, (phase == 1) ? '0 : random_mac(),
                mac_pool[$urandom_range(MacPoolSize - 1)], random_mac(),
                (phase == 3) ? '1 : random_mac());
      for (i = 0; i < RandPerPhase; i++) begin
        frame_q.push_back(random_frame());
        frames_queued++;
      end
      drain();
    end

    repeat (80) @(posedge clk_i);
    $display("covered %0d frames: %0d forwarded, %0d flooded, %0d local", frames_taken,
             n_forward, n_flood, n_local);
    $display("table learned %0d new sources and wrapped %0d times; %0d errors", n_learned,
             n_wrapped, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/mlf_pkg.sv
design/mlf_if.sv
design/mlf_ram.sv
design/mac_learning_forwarder.sv
verif/mac_learning_forwarder_tb.sv
